### hdl/rtt_pkg.sv
// Shared types and constants of the repeating timer table.
`timescale 1ns / 1ps
package rtt_pkg;

    localparam int SLOTS       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int ID_W        = 20;
    localparam int TIME_W      = 32;
    localparam int VAL_W       = 16;
    localparam int DUE_W       = 2 * VAL_W + 1;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    localparam logic [1:0] KIND_FIRED   = 2'd0;
    localparam logic [1:0] KIND_STARTED = 2'd1;
    localparam logic [1:0] KIND_FULL    = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [VAL_W-1:0]  period;
        logic [VAL_W-1:0]  limit;
        logic [VAL_W-1:0]  fired;
        logic [ID_W-1:0]   ident;
    } t_slot;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             late;
    } t_eval;

endpackage

### hdl/rtt_if.sv
// Request and result channels of the repeating timer table.
`timescale 1ns / 1ps
interface rtt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] period;
    logic [15:0] repeat_limit;
    logic [19:0] target_id;

    modport source (output valid, action, period, repeat_limit, target_id, input ready);
    modport sink   (input valid, action, period, repeat_limit, target_id, output ready);
endinterface

interface rtt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [19:0] timer_id;
    logic        last;

    modport source (output valid, kind, timer_id, last, input ready);
    modport sink   (input valid, kind, timer_id, last, output ready);
endinterface

### hdl/repeating_timer_table.sv
// Top level of the repeating timer table: control, slot memory and result register.
`timescale 1ns / 1ps
// Table of SLOTS repeating timers. A tick item advances the time counter and
// walks every slot once through the slot memory, one read per cycle, in index
// order; each slot that is due gives one fired item, and the last item of the
// tick carries last. A stop walks the slots the same way. Each walk passes
// through one read of the slot memory (one write port, one registered read
// port) per slot, the due check of rtt_slot_eval behind it, and the flush
// state that releases the final fired item. A start always gives one item,
// started or full. A stop gives no item. Requests are taken one at a time;
// a waiting result holds the slot walk.
module repeating_timer_table
    import rtt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    rtt_in_if.sink   i_in,
    rtt_out_if.source o_out
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    t_state            r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [VAL_W-1:0]  r_period, n_period;
    logic [VAL_W-1:0]  r_limit, n_limit;
    logic [ID_W-1:0]   r_target, n_target;
    logic [TIME_W-1:0] r_now, n_now;
    logic [ID_W-1:0]   r_next_id, n_next_id;
    logic [SLOTS-1:0]  r_done, n_done;
    logic [IDX_W-1:0]  r_addr, n_addr;
    logic              r_issue, n_issue;
    logic [CNT_W-1:0]  r_fire_cnt, n_fire_cnt;
    logic              r_pend_valid, n_pend_valid;
    logic [ID_W-1:0]   r_pend_id, n_pend_id;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_out_kind, n_out_kind;
    logic [ID_W-1:0]   r_out_id, n_out_id;
    logic              r_out_last, n_out_last;
    logic              r_s1_valid;
    logic [IDX_W-1:0]  r_s1_idx;

    t_slot             r_mem [SLOTS];
    t_slot             r_rd;

    logic              out_free;
    logic              adv;
    logic              rd_en;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    t_slot             mem_wdata;
    logic              free_any;
    logic [IDX_W-1:0]  free_idx;
    t_eval             s2;
    t_slot             s2_ent;
    logic              chk;
    logic              fire;
    logic              stop_hit;
    logic [VAL_W-1:0]  fired_nx;
    logic [VAL_W-1:0]  lim_eff;
    logic              in_acc;

    assign out_free = !r_out_valid || o_out.ready;
    assign adv      = out_free;
    assign rd_en    = (r_state == S_SCAN) && adv && r_issue;
    assign in_acc   = i_in.valid && i_in.ready;

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.kind     = r_out_kind;
    assign o_out.timer_id = r_out_id;
    assign o_out.last     = r_out_last;

    // lowest free slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (r_done[k]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(k);
            end
        end
    end

    rtt_slot_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_s1_valid),
        .i_idx   (r_s1_idx),
        .i_ent   (r_rd),
        .i_now   (r_now),
        .o_stat  (s2),
        .o_ent   (s2_ent)
    );

    always_comb begin
        fired_nx = s2_ent.fired + {{(VAL_W-1){1'b0}}, 1'b1};
        lim_eff  = (s2_ent.limit == '0) ? {{(VAL_W-1){1'b0}}, 1'b1} : s2_ent.limit;
        // slots past the per-tick cap are left untouched for a later tick
        chk      = s2.valid && (r_op == ACT_TICK) && !r_done[s2.idx] &&
                   (r_fire_cnt < CNT_W'(MAX_RESULTS));
        fire     = chk && s2.late;
        stop_hit = s2.valid && (r_op == ACT_STOP) && !r_done[s2.idx] &&
                   (s2_ent.ident == r_target);
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_period     = r_period;
        n_limit      = r_limit;
        n_target     = r_target;
        n_now        = r_now;
        n_next_id    = r_next_id;
        n_done       = r_done;
        n_addr       = r_addr;
        n_issue      = r_issue;
        n_fire_cnt   = r_fire_cnt;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_kind   = r_out_kind;
        n_out_id     = r_out_id;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mem_waddr    = s2.idx;
        mem_wdata    = s2_ent;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op       = i_in.action;
                    n_period   = i_in.period;
                    n_limit    = i_in.repeat_limit;
                    n_target   = i_in.target_id;
                    n_addr     = '0;
                    n_issue    = 1'b1;
                    n_fire_cnt = '0;
                    if (i_in.action == ACT_TICK) begin
                        n_now   = r_now + {{(TIME_W-1){1'b0}}, 1'b1};
                        n_state = S_SCAN;
                    end else if (i_in.action == ACT_STOP) begin
                        n_state = S_SCAN;
                    end else if (i_in.action == ACT_START) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                    if (free_any) begin
                        mem_we          = 1'b1;
                        mem_waddr       = free_idx;
                        mem_wdata.start  = r_now;
                        mem_wdata.period = r_period;
                        mem_wdata.limit  = r_limit;
                        mem_wdata.fired  = '0;
                        mem_wdata.ident  = r_next_id;
                        n_done[free_idx] = 1'b0;
                        n_out_kind      = KIND_STARTED;
                        n_out_id        = r_next_id;
                        n_next_id       = r_next_id + {{(ID_W-1){1'b0}}, 1'b1};
                    end else begin
                        n_out_kind = KIND_FULL;
                        n_out_id   = '0;
                    end
                end
            end
            S_SCAN: begin
                if (adv) begin
                    if (r_issue) begin
                        if (r_addr == LAST_IDX) begin
                            n_issue = 1'b0;
                        end else begin
                            n_addr = r_addr + {{(IDX_W-1){1'b0}}, 1'b1};
                        end
                    end
                    if (fire) begin
                        mem_we          = 1'b1;
                        mem_wdata.fired = fired_nx;
                        n_fire_cnt      = r_fire_cnt + {{(CNT_W-1){1'b0}}, 1'b1};
                        if (fired_nx >= lim_eff) begin
                            n_done[s2.idx] = 1'b1;
                        end
                        // hold the newest fire until we know whether it is the last
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_FIRED;
                            n_out_id    = r_pend_id;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_id    = s2_ent.ident;
                    end
                    if (stop_hit) begin
                        n_done[s2.idx] = 1'b1;
                    end
                    if (s2.valid && s2.idx == LAST_IDX) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_FIRED;
                    n_out_id     = r_pend_id;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_now        <= '0;
            r_next_id    <= '0;
            r_done       <= '1;
            r_issue      <= 1'b0;
            r_fire_cnt   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_s1_valid   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_now        <= n_now;
            r_next_id    <= n_next_id;
            r_done       <= n_done;
            r_issue      <= n_issue;
            r_fire_cnt   <= n_fire_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (adv) begin
                r_s1_valid <= rd_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_period   <= n_period;
        r_limit    <= n_limit;
        r_target   <= n_target;
        r_addr     <= n_addr;
        r_pend_id  <= n_pend_id;
        r_out_kind <= n_out_kind;
        r_out_id   <= n_out_id;
        r_out_last <= n_out_last;
        if (rd_en) begin
            r_s1_idx <= r_addr;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd <= r_mem[r_addr];
        end
    end

    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_state == S_SCAN || r_state == S_FLUSH))
        else $error("pending fire outside a tick walk");

    a_fire_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fire_cnt <= CNT_W'(MAX_RESULTS))
        else $error("fire count above cap");

    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START && out_free) |=> (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("start did not produce its item");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_START || (r_state == S_SCAN && fire)))
        else $error("slot memory written outside start or fire");

endmodule

### hdl/rtt_slot_eval.sv
// Due-time stage: elapsed time and (fired + 1) * period for one slot entry.
`timescale 1ns / 1ps
module rtt_slot_eval
    import rtt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [IDX_W-1:0]  i_idx,
    input  t_slot             i_ent,
    input  logic [TIME_W-1:0] i_now,
    output t_eval             o_stat,
    output t_slot             o_ent
);

    logic              r_valid;
    logic [IDX_W-1:0]  r_idx;
    t_slot             r_ent;
    logic [TIME_W-1:0] r_elapsed;
    logic [DUE_W-1:0]  r_due;

    logic [VAL_W:0]    fired_p1;
    logic [DUE_W-1:0]  n_due;

    always_comb begin
        fired_p1 = {1'b0, i_ent.fired} + {{VAL_W{1'b0}}, 1'b1};
        n_due    = {{(DUE_W-VAL_W-1){1'b0}}, fired_p1} * {{(DUE_W-VAL_W){1'b0}}, i_ent.period};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_idx     <= i_idx;
            r_ent     <= i_ent;
            r_elapsed <= i_now - i_ent.start;
            r_due     <= n_due;
        end
    end

    assign o_stat.valid = r_valid;
    assign o_stat.idx   = r_idx;
    assign o_stat.late  = {{(DUE_W-TIME_W){1'b0}}, r_elapsed} > r_due;
    assign o_ent        = r_ent;

endmodule

### sim/repeating_timer_table_tb.sv
// Self-checking testbench of the repeating timer table.
`timescale 1ns / 1ps
module repeating_timer_table_tb;
    import rtt_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         RUN_ITEMS   = 220;
    localparam int         STALL_LIMIT = 2000;
    localparam int         DRAIN_CYCLES = 2 * SLOTS + 8;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] timer_id;
        logic            last;
    } t_timer_event;

    // Timer table predictor: holds the expected events of every accepted request.
    class timer_scoreboard;
        logic [TIME_W-1:0] now_t;
        logic [ID_W-1:0]   next_id;
        bit                idle_slot [SLOTS];
        logic [TIME_W-1:0] start_t [SLOTS];
        logic [VAL_W-1:0]  period_t [SLOTS];
        logic [VAL_W-1:0]  limit_t [SLOTS];
        logic [VAL_W-1:0]  fired_t [SLOTS];
        logic [ID_W-1:0]   ident_t [SLOTS];
        t_timer_event      pending [$];
        int                mismatches;

        function new();
            now_t      = '0;
            next_id    = '0;
            mismatches = 0;
            foreach (idle_slot[i]) idle_slot[i] = 1'b1;
        endfunction

        function void note_item(logic [1:0] action, logic [VAL_W-1:0] period,
                                logic [VAL_W-1:0] limit, logic [ID_W-1:0] target);
            t_timer_event      evs [$];
            t_timer_event      ev;
            logic [TIME_W-1:0] elapsed;
            logic [DUE_W-1:0]  due;
            logic [VAL_W-1:0]  lim;
            bit                placed;
            placed = 1'b0;
            case (action)
                ACT_TICK: begin
                    now_t = now_t + 1'b1;
                    for (int i = 0; i < SLOTS && evs.size() < MAX_RESULTS; i++) begin
                        if (!idle_slot[i]) begin
                            elapsed = now_t - start_t[i];
                            due = (DUE_W'(fired_t[i]) + 1'b1) * DUE_W'(period_t[i]);
                            if (DUE_W'(elapsed) > due) begin
                                fired_t[i] = fired_t[i] + 1'b1;
                                ev.kind     = KIND_FIRED;
                                ev.timer_id = ident_t[i];
                                ev.last     = 1'b0;
                                evs.insert(evs.size(), ev);
                                lim = (limit_t[i] == '0) ? VAL_W'(1) : limit_t[i];
                                if (fired_t[i] >= lim) idle_slot[i] = 1'b1;
                            end
                        end
                    end
                end
                ACT_START: begin
                    ev.kind     = KIND_FULL;
                    ev.timer_id = '0;
                    ev.last     = 1'b0;
                    for (int i = 0; i < SLOTS && !placed; i++) begin
                        if (idle_slot[i]) begin
                            placed       = 1'b1;
                            idle_slot[i] = 1'b0;
                            start_t[i]   = now_t;
                            period_t[i]  = period;
                            limit_t[i]   = limit;
                            fired_t[i]   = '0;
                            ident_t[i]   = next_id;
                            ev.kind      = KIND_STARTED;
                            ev.timer_id  = next_id;
                            next_id      = next_id + 1'b1;
                        end
                    end
                    evs.insert(evs.size(), ev);
                end
                ACT_STOP: begin
                    foreach (idle_slot[i])
                        if (!idle_slot[i] && ident_t[i] == target) idle_slot[i] = 1'b1;
                end
                default: ;
            endcase
            if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
            foreach (evs[i]) pending.insert(pending.size(), evs[i]);
        endfunction

        function void check_result(logic [1:0] kind, logic [ID_W-1:0] timer_id, logic last);
            t_timer_event exp_ev;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: kind %0d id %0d last %0d",
                             kind, timer_id, last);
                return;
            end
            exp_ev = pending.pop_front();
            if (kind !== exp_ev.kind || timer_id !== exp_ev.timer_id
                    || last !== exp_ev.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected kind %0d id %0d last %0d, ",
                              "got kind %0d id %0d last %0d"},
                             exp_ev.kind, exp_ev.timer_id, exp_ev.last,
                             kind, timer_id, last);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   idle_on;
    int   quiet_cycles;
    timer_scoreboard sb;

    rtt_in_if  req_if ();
    rtt_out_if res_if ();

    repeating_timer_table dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic [1:0] action, logic [VAL_W-1:0] period,
                             logic [VAL_W-1:0] limit, logic [ID_W-1:0] target);
        while (idle_on && $urandom_range(99) < 30) begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.action       <= action;
        req_if.period       <= period;
        req_if.repeat_limit <= limit;
        req_if.target_id    <= target;
        do @(posedge clk); while (!req_if.ready);
        sb.note_item(action, period, limit, target);
        @(negedge clk);
    endtask

    task automatic tick();
        send_item(ACT_TICK, VAL_W'($urandom), VAL_W'($urandom), ID_W'($urandom));
    endtask

    task automatic start_timer(logic [VAL_W-1:0] period, logic [VAL_W-1:0] limit);
        send_item(ACT_START, period, limit, ID_W'($urandom));
    endtask

    task automatic stop_timer(logic [ID_W-1:0] target);
        send_item(ACT_STOP, VAL_W'($urandom), VAL_W'($urandom), target);
    endtask

    // Result side: ready changes at the falling edge, items are taken at the rising edge.
    always @(negedge clk)
        res_if.ready <= !idle_on || ($urandom_range(99) >= 30);

    always @(posedge clk)
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.kind, res_if.timer_id, res_if.last);

    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int               counted;
        int unsigned      pick;
        logic [VAL_W-1:0] per;
        logic [VAL_W-1:0] lim;
        logic [ID_W-1:0]  tgt;

        sb                  = new();
        rst_n               = 1'b0;
        idle_on             = 1'b1;
        req_if.valid        = 1'b0;
        req_if.action       = ACT_TICK;
        req_if.period       = '0;
        req_if.repeat_limit = '0;
        req_if.target_id    = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero period and limit, field extremes, stops, unused action.
        start_timer(16'd0, 16'd0);
        start_timer(16'hFFFF, 16'hFFFF);
        start_timer(16'd1, 16'd3);
        tick();
        tick();
        tick();
        stop_timer(20'hFFFFF);
        stop_timer(20'd1);
        send_item(ACT_UNUSED, VAL_W'($urandom), VAL_W'($urandom), ID_W'($urandom));
        // Fill the table, overflow it once, then fire every running slot in one tick.
        for (int k = 0; k < 16; k++) start_timer(16'd0, (k == 0) ? 16'd0 : 16'd1);
        tick();
        tick();
        stop_timer(20'd2);

        counted = 0;
        while (counted < RUN_ITEMS) begin
            idle_on = !(counted >= 100 && counted < 160);
            pick = $urandom_range(99);
            if (pick < 45) begin
                tick();
                counted++;
            end else if (pick < 75) begin
                pick = $urandom_range(99);
                per = (pick < 70) ? VAL_W'($urandom_range(6)) :
                      (pick < 90) ? VAL_W'($urandom_range(40, 7)) : VAL_W'($urandom);
                pick = $urandom_range(99);
                lim = (pick < 60) ? VAL_W'($urandom_range(4)) :
                      (pick < 90) ? VAL_W'($urandom_range(20, 5)) : VAL_W'($urandom);
                start_timer(per, lim);
                counted++;
            end else if (pick < 92) begin
                // Aim most stops at recently issued ids so long timers get cleared.
                if ($urandom_range(99) < 70)
                    tgt = sb.next_id - ID_W'(1) - ID_W'($urandom_range(19));
                else
                    tgt = ID_W'($urandom);
                stop_timer(tgt);
                counted++;
            end else begin
                send_item(ACT_UNUSED, VAL_W'($urandom), VAL_W'($urandom), ID_W'($urandom));
            end
        end
        req_if.valid <= 1'b0;
        idle_on = 1'b1;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
